// ===== rtl/ucd_pkg.sv =====
// shared types and constants for the utf-8 code point decoder
// used by ucd_front, ucd_queue, ucd_back and utf8_codepoint_decoder
`timescale 1ns / 1ps

package ucd_pkg;

  localparam int unsigned CP_W    = 21;
  localparam int unsigned MAX_RES = 4;
  localparam int unsigned CNT_W   = 3;   // holds 0..MAX_RES
  localparam int unsigned PART_W  = 15;  // bits gathered before the final byte

  localparam logic [CP_W-1:0] MAL_BASE = 21'h110000;
  localparam logic [CP_W-1:0] MIN_LEN2 = 21'h000080;
  localparam logic [CP_W-1:0] MIN_LEN3 = 21'h000800;
  localparam logic [CP_W-1:0] MIN_LEN4 = 21'h010000;
  localparam logic [CP_W-1:0] SURR_LO  = 21'h00D800;
  localparam logic [CP_W-1:0] SURR_HI  = 21'h00DFFF;
  localparam logic [CP_W-1:0] CP_MAX   = 21'h10FFFF;

  // expected sequence length codes
  localparam logic [2:0] LEN_NONE = 3'd0;
  localparam logic [2:0] LEN2     = 3'd2;
  localparam logic [2:0] LEN3     = 3'd3;
  localparam logic [2:0] LEN4     = 3'd4;

  typedef struct packed {
    logic [CP_W-1:0] value;
    logic            mal;
  } res_t;

  // all results caused by one input byte
  typedef struct packed {
    logic [CNT_W-1:0]       count;
    logic                   eot;
    res_t [MAX_RES-1:0]     slot;
  } cmd_t;

endpackage

// ===== rtl/ucd_front.sv =====
// front end: accepts bytes, tracks the open sequence, builds the result list
// depends on ucd_pkg
`timescale 1ns / 1ps

module ucd_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [7:0]    in_byte,
  input  logic          in_eot,
  input  logic          q_full,
  output logic          in_ready,
  output logic          push,
  output ucd_pkg::cmd_t cmd
);

  logic [2:0]                     exp_len, exp_len_next;
  logic [1:0]                     held, held_next;
  logic [7:0]                     lead, lead_next;
  logic [ucd_pkg::PART_W-1:0]     part, part_next;
  logic [1:0][5:0]                conts, conts_next;

  logic                           accept;
  logic                           is_cont;
  logic                           consumed;
  logic                           complete;
  logic                           cp_ok;
  logic [ucd_pkg::CP_W-1:0]       cp;
  logic [ucd_pkg::CNT_W-1:0]      n;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && (cmd.count != '0);

  assign is_cont  = (in_byte[7:6] == 2'b10);
  assign cp       = {part, in_byte[5:0]};
  assign complete = (({1'b0, held} + 3'd2) >= exp_len);

  always_comb begin
    cp_ok = 1'b1;
    if (exp_len == ucd_pkg::LEN2 && cp < ucd_pkg::MIN_LEN2) cp_ok = 1'b0;
    if (exp_len == ucd_pkg::LEN3 && cp < ucd_pkg::MIN_LEN3) cp_ok = 1'b0;
    if (exp_len == ucd_pkg::LEN4 && cp < ucd_pkg::MIN_LEN4) cp_ok = 1'b0;
    if (cp >= ucd_pkg::SURR_LO && cp <= ucd_pkg::SURR_HI) cp_ok = 1'b0;
    if (cp > ucd_pkg::CP_MAX) cp_ok = 1'b0;
  end

  always_comb begin
    exp_len_next = exp_len;
    held_next    = held;
    lead_next    = lead;
    part_next    = part;
    conts_next   = conts;
    consumed     = 1'b0;
    n            = '0;
    cmd          = '0;
    cmd.eot      = in_eot;

    if (exp_len != ucd_pkg::LEN_NONE) begin
      if (is_cont) begin
        consumed = 1'b1;
        if (complete) begin
          if (cp_ok) begin
            cmd.slot[n[1:0]] = '{value: cp, mal: 1'b0};
            n = n + 3'd1;
          end else begin
            cmd.slot[n[1:0]] = '{value: ucd_pkg::MAL_BASE | {13'd0, lead}, mal: 1'b1};
            n = n + 3'd1;
            if (held != 2'd0) begin
              cmd.slot[n[1:0]] = '{value: {13'd0, 2'b10, conts[0]}, mal: 1'b0};
              n = n + 3'd1;
            end
            if (held == 2'd2) begin
              cmd.slot[n[1:0]] = '{value: {13'd0, 2'b10, conts[1]}, mal: 1'b0};
              n = n + 3'd1;
            end
            cmd.slot[n[1:0]] = '{value: {13'd0, in_byte}, mal: 1'b0};
            n = n + 3'd1;
          end
          exp_len_next = ucd_pkg::LEN_NONE;
          held_next    = '0;
          lead_next    = '0;
          part_next    = '0;
        end else begin
          // hold this continuation and keep gathering
          conts_next[held[0]] = in_byte[5:0];
          held_next           = held + 2'd1;
          part_next           = cp[ucd_pkg::PART_W-1:0];
        end
      end else begin
        // sequence broken by a non-continuation byte
        cmd.slot[n[1:0]] = '{value: ucd_pkg::MAL_BASE | {13'd0, lead}, mal: 1'b1};
        n = n + 3'd1;
        if (held != 2'd0) begin
          cmd.slot[n[1:0]] = '{value: {13'd0, 2'b10, conts[0]}, mal: 1'b0};
          n = n + 3'd1;
        end
        if (held == 2'd2) begin
          cmd.slot[n[1:0]] = '{value: {13'd0, 2'b10, conts[1]}, mal: 1'b0};
          n = n + 3'd1;
        end
        exp_len_next = ucd_pkg::LEN_NONE;
        held_next    = '0;
        lead_next    = '0;
        part_next    = '0;
      end
    end

    if (!consumed) begin
      if (in_byte[7:5] == 3'b110) begin
        lead_next    = in_byte;
        part_next    = {10'd0, in_byte[4:0]};
        exp_len_next = ucd_pkg::LEN2;
        held_next    = '0;
      end else if (in_byte[7:4] == 4'b1110) begin
        lead_next    = in_byte;
        part_next    = {11'd0, in_byte[3:0]};
        exp_len_next = ucd_pkg::LEN3;
        held_next    = '0;
      end else if (in_byte[7:3] == 5'b11110) begin
        lead_next    = in_byte;
        part_next    = {12'd0, in_byte[2:0]};
        exp_len_next = ucd_pkg::LEN4;
        held_next    = '0;
      end else begin
        cmd.slot[n[1:0]] = '{value: {13'd0, in_byte}, mal: 1'b0};
        n = n + 3'd1;
      end
    end

    // end of text flushes whatever is still open
    if (in_eot && exp_len_next != ucd_pkg::LEN_NONE) begin
      cmd.slot[n[1:0]] = '{value: ucd_pkg::MAL_BASE | {13'd0, lead_next}, mal: 1'b1};
      n = n + 3'd1;
      if (held_next != 2'd0) begin
        cmd.slot[n[1:0]] = '{value: {13'd0, 2'b10, conts_next[0]}, mal: 1'b0};
        n = n + 3'd1;
      end
      if (held_next == 2'd2) begin
        cmd.slot[n[1:0]] = '{value: {13'd0, 2'b10, conts_next[1]}, mal: 1'b0};
        n = n + 3'd1;
      end
      exp_len_next = ucd_pkg::LEN_NONE;
      held_next    = '0;
      lead_next    = '0;
      part_next    = '0;
    end

    cmd.count = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      exp_len <= ucd_pkg::LEN_NONE;
      held    <= '0;
      lead    <= '0;
      part    <= '0;
    end else if (accept) begin
      exp_len <= exp_len_next;
      held    <= held_next;
      lead    <= lead_next;
      part    <= part_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      conts <= conts_next;
    end
  end

endmodule

// ===== rtl/ucd_queue.sv =====
// short queue of per-byte result lists between front and back
// depends on ucd_pkg
`timescale 1ns / 1ps

module ucd_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ucd_pkg::cmd_t wr_cmd,
  input  logic          pop,
  output logic          full,
  output logic          empty,
  output ucd_pkg::cmd_t rd_cmd
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  ucd_pkg::cmd_t    mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full   = (count == CNT_W'(DEPTH));
  assign empty  = (count == '0);
  assign rd_cmd = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/ucd_back.sv =====
// back end: walks the head result list into the output register, one code point per cycle
// while out_ready allows; depends on ucd_pkg
`timescale 1ns / 1ps

module ucd_back (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     q_empty,
  input  ucd_pkg::cmd_t            head,
  output logic                     pop,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [ucd_pkg::CP_W-1:0] out_value,
  output logic                     out_mal,
  output logic                     out_last,
  output logic                     out_done
);

  logic [1:0] idx;
  logic       load;
  logic       at_last;

  assign load    = !q_empty && (!out_valid || out_ready);
  assign at_last = ({1'b0, idx} == (head.count - 3'd1));
  assign pop     = load && at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= at_last ? 2'd0 : idx + 2'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_value <= head.slot[idx].value;
      out_mal   <= head.slot[idx].mal;
      out_last  <= at_last;
      out_done  <= at_last && head.eot;
    end
  end

endmodule

// ===== rtl/utf8_codepoint_decoder.sv =====
// utf-8 to code point decoder, top level; uses ucd_pkg, ucd_front, ucd_queue, ucd_back
// order: a byte's results are written to the queue at its transaction, then loaded one by one
//   into the output register that drives m_tvalid
// throughput: one byte per cycle while each byte gives at most one code point and m_tready
//   stays high; a byte that gives k results (malformed replay, up to 4) holds the output for k
//   transactions, the queue absorbs up to QDEPTH such lists before s_tready drops
// reset: rst synchronous active high, clears sequence state, queue pointers and m_tvalid
`timescale 1ns / 1ps

module utf8_codepoint_decoder #(
  parameter int unsigned QDEPTH = 2  // result lists buffered between front and back, >= 2
) (
  input  logic        clk,
  input  logic        rst,

  // byte input
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  input  logic        s_tlast,   // end_of_text

  // code point output
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [20:0] code_value, [23:21] zero
  output logic        m_tlast,   // last_of_run
  output logic [1:0]  m_tuser    // [0] malformed, [1] text_done
);

  // front to queue
  logic          push;
  logic          q_full;
  ucd_pkg::cmd_t wr_cmd;

  // queue to back
  logic          pop;
  logic          q_empty;
  ucd_pkg::cmd_t head;

  logic [ucd_pkg::CP_W-1:0] code_value;
  logic                     malformed;
  logic                     text_done;

  // front: decodes each byte transaction into a list of 0..4 results
  ucd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_byte  (s_tdata),
    .in_eot   (s_tlast),
    .q_full   (q_full),
    .in_ready (s_tready),
    .push     (push),
    .cmd      (wr_cmd)
  );

  // bytes that only open or extend a sequence push nothing
  ucd_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_cmd (wr_cmd),
    .pop    (pop),
    .full   (q_full),
    .empty  (q_empty),
    .rd_cmd (head)
  );

  // back: one code point per output transaction, registered
  ucd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .head      (head),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_value (code_value),
    .out_mal   (malformed),
    .out_last  (m_tlast),
    .out_done  (text_done)
  );

  assign m_tdata = {3'b000, code_value};
  assign m_tuser = {text_done, malformed};

endmodule

// ===== tb/tb_utf8_codepoint_decoder.sv =====
// self-checking testbench for utf8_codepoint_decoder: directed table, then random byte streams
// depends on rtl/ucd_pkg.sv and the decoder rtl; reference predictor is built in below
`timescale 1ns / 1ps

module tb_utf8_codepoint_decoder;

  // one expected code point transaction on the output side
  typedef struct packed {
    logic [20:0] value;
    logic        mal;
    logic        last;
    logic        done;
  } cp_res_t;

  // one row of the directed table; typed rows carry their single known result
  typedef struct packed {
    logic [7:0]  b;
    logic        eot;
    logic        typed;
    logic [20:0] cp;
    logic        mal;
  } dir_row_t;

  localparam int DIR_N = 25;

  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    // plain bytes at the extremes, stray continuation
    '{8'h00, 1'b0, 1'b1, 21'h000000, 1'b0},
    '{8'h7F, 1'b0, 1'b1, 21'h00007F, 1'b0},
    '{8'h80, 1'b0, 1'b1, 21'h000080, 1'b0},
    '{8'hFF, 1'b0, 1'b1, 21'h0000FF, 1'b0},
    // smallest legal two-byte form
    '{8'hC2, 1'b0, 1'b0, 21'h0, 1'b0},
    '{8'h80, 1'b0, 1'b0, 21'h0, 1'b0},
    // overlong two-byte form on a C0 lead
    '{8'hC0, 1'b0, 1'b0, 21'h0, 1'b0},
    '{8'hAF, 1'b0, 1'b0, 21'h0, 1'b0},
    // surrogate
    '{8'hED, 1'b0, 1'b0, 21'h0, 1'b0},
    '{8'hA0, 1'b0, 1'b0, 21'h0, 1'b0},
    '{8'h80, 1'b0, 1'b0, 21'h0, 1'b0},
    // above the code space, four results from one byte
    '{8'hF5, 1'b0, 1'b0, 21'h0, 1'b0},
    '{8'h80, 1'b0, 1'b0, 21'h0, 1'b0},
    '{8'h80, 1'b0, 1'b0, 21'h0, 1'b0},
    '{8'h80, 1'b0, 1'b0, 21'h0, 1'b0},
    // legal four-byte form
    '{8'hF0, 1'b0, 1'b0, 21'h0, 1'b0},
    '{8'h9F, 1'b0, 1'b0, 21'h0, 1'b0},
    '{8'h98, 1'b0, 1'b0, 21'h0, 1'b0},
    '{8'h80, 1'b0, 1'b0, 21'h0, 1'b0},
    // broken by a plain byte after two held continuations
    '{8'hF0, 1'b0, 1'b0, 21'h0, 1'b0},
    '{8'h90, 1'b0, 1'b0, 21'h0, 1'b0},
    '{8'h80, 1'b0, 1'b0, 21'h0, 1'b0},
    '{8'h41, 1'b0, 1'b0, 21'h0, 1'b0},
    // text ends on a bare lead, then inside a three-byte form
    '{8'hC3, 1'b1, 1'b1, ucd_pkg::MAL_BASE + 21'h0000C3, 1'b1},
    '{8'hE1, 1'b0, 1'b0, 21'h0, 1'b0}
  };

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // [7:0] in_byte
  logic        s_tlast;   // end_of_text
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;   // [20:0] code_value, [23:21] zero
  logic        m_tlast;   // last_of_run
  logic [1:0]  m_tuser;   // [0] malformed, [1] text_done

  // decoder state mirrored by the predictor
  logic [7:0]  lead_q;
  logic [20:0] acc_q;
  logic [2:0]  len_q;
  logic [1:0]  nheld_q;
  logic [5:0]  cont_q [3];

  cp_res_t     byte_results [$];   // results of the byte being predicted
  cp_res_t     cp_expect_q [$];    // code points still owed by the dut
  logic [7:0]  chunk_q [$];        // bytes of the current random fragment

  int          tx_idle_pct  = 0;
  int          rx_stall_pct = 0;
  logic        rx_hold      = 1'b0;
  event        hold_go;

  int          err_count  = 0;
  int          bytes_sent = 0;
  int          cp_seen    = 0;
  int          mal_seen   = 0;
  int          texts_seen = 0;

  utf8_codepoint_decoder DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic void seq_clear();
    lead_q  = 8'h00;
    acc_q   = '0;
    len_q   = ucd_pkg::LEN_NONE;
    nheld_q = 2'd0;
  endfunction

  function automatic void add_result(logic [20:0] v, logic mal);
    byte_results.insert(byte_results.size(), '{value: v, mal: mal, last: 1'b0, done: 1'b0});
  endfunction

  // lead goes out marked malformed, then every continuation held so far
  function automatic void reject_seq();
    int k;
    add_result(ucd_pkg::MAL_BASE + {13'd0, lead_q}, 1'b1);
    for (k = 0; k < int'(nheld_q); k++) add_result({13'd0, 2'b10, cont_q[k]}, 1'b0);
    seq_clear();
  endfunction

  function automatic bit cp_legal(logic [2:0] len, logic [20:0] cp);
    if (len == ucd_pkg::LEN2 && cp < ucd_pkg::MIN_LEN2) return 1'b0;
    if (len == ucd_pkg::LEN3 && cp < ucd_pkg::MIN_LEN3) return 1'b0;
    if (len == ucd_pkg::LEN4 && cp < ucd_pkg::MIN_LEN4) return 1'b0;
    if (cp >= ucd_pkg::SURR_LO && cp <= ucd_pkg::SURR_HI) return 1'b0;
    if (cp > ucd_pkg::CP_MAX) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void open_seq(logic [7:0] b, logic [2:0] len, logic [20:0] bits);
    lead_q  = b;
    acc_q   = bits;
    len_q   = len;
    nheld_q = 2'd0;
  endfunction

  // works out every code point one input byte causes, into byte_results
  function automatic void decode_byte(logic [7:0] b, logic eot);
    logic [20:0] cp;
    bit          took;
    took = 1'b0;
    byte_results.delete();
    if (len_q != ucd_pkg::LEN_NONE) begin
      if (b[7:6] == 2'b10) begin
        cp   = {acc_q[14:0], b[5:0]};
        took = 1'b1;
        if (int'(nheld_q) + 2 >= int'(len_q)) begin
          if (cp_legal(len_q, cp)) begin
            add_result(cp, 1'b0);
            seq_clear();
          end else begin
            // the closing byte is replayed after the held ones
            reject_seq();
            add_result({13'd0, b}, 1'b0);
          end
        end else begin
          cont_q[nheld_q] = b[5:0];
          nheld_q         = nheld_q + 2'd1;
          acc_q           = cp;
        end
      end else begin
        reject_seq();
      end
    end
    if (!took) begin
      if (b[7:5] == 3'b110) open_seq(b, ucd_pkg::LEN2, {16'd0, b[4:0]});
      else if (b[7:4] == 4'b1110) open_seq(b, ucd_pkg::LEN3, {17'd0, b[3:0]});
      else if (b[7:3] == 5'b11110) open_seq(b, ucd_pkg::LEN4, {18'd0, b[2:0]});
      else add_result({13'd0, b}, 1'b0);
    end
    if (eot && len_q != ucd_pkg::LEN_NONE) reject_seq();
  endfunction

  // ---------------------------------------------------------------------------
  // byte driver
  // ---------------------------------------------------------------------------

  // offers one byte, waits for its transaction, then books its results
  task automatic send_byte(input logic [7:0] b, input logic eot, input logic typed,
                           input logic [20:0] tcp, input logic tmal);
    cp_res_t r;
    int      i;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= eot;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    decode_byte(b, eot);
    if (typed) begin
      // predictor state still advances, but the known value is what gets checked
      byte_results.delete();
      add_result(tcp, tmal);
    end
    for (i = 0; i < byte_results.size(); i++) begin
      r      = byte_results[i];
      r.last = (i == byte_results.size() - 1);
      r.done = r.last && eot;
      cp_expect_q.insert(cp_expect_q.size(), r);
    end
    bytes_sent++;
  endtask

  task automatic drain();
    while (cp_expect_q.size() != 0) @(posedge clk);
  endtask

  function automatic void encode_cp(logic [20:0] cp, logic [2:0] len);
    case (len)
      ucd_pkg::LEN2: begin
        chunk_q.insert(chunk_q.size(), {3'b110, cp[10:6]});
        chunk_q.insert(chunk_q.size(), {2'b10, cp[5:0]});
      end
      ucd_pkg::LEN3: begin
        chunk_q.insert(chunk_q.size(), {4'b1110, cp[15:12]});
        chunk_q.insert(chunk_q.size(), {2'b10, cp[11:6]});
        chunk_q.insert(chunk_q.size(), {2'b10, cp[5:0]});
      end
      default: begin
        chunk_q.insert(chunk_q.size(), {5'b11110, cp[20:18]});
        chunk_q.insert(chunk_q.size(), {2'b10, cp[17:12]});
        chunk_q.insert(chunk_q.size(), {2'b10, cp[11:6]});
        chunk_q.insert(chunk_q.size(), {2'b10, cp[5:0]});
      end
    endcase
  endfunction

  function automatic logic [20:0] legal_cp(logic [2:0] len);
    logic [20:0] cp;
    case (len)
      ucd_pkg::LEN2: cp = 21'($urandom_range(ucd_pkg::MIN_LEN3 - 1, ucd_pkg::MIN_LEN2));
      ucd_pkg::LEN3: begin
        cp = 21'($urandom_range(ucd_pkg::MIN_LEN4 - 1, ucd_pkg::MIN_LEN3));
        while (cp >= ucd_pkg::SURR_LO && cp <= ucd_pkg::SURR_HI) begin
          cp = 21'($urandom_range(ucd_pkg::MIN_LEN4 - 1, ucd_pkg::MIN_LEN3));
        end
      end
      default: cp = 21'($urandom_range(ucd_pkg::CP_MAX, ucd_pkg::MIN_LEN4));
    endcase
    return cp;
  endfunction

  // mostly well-formed text, with bad forms, cut sequences and raw noise mixed in
  function automatic void build_chunk();
    int          r;
    int          cut;
    logic [2:0]  len;
    logic [20:0] cp;
    r   = $urandom_range(99);
    len = 3'($urandom_range(4, 2));
    if (r < 25) begin
      chunk_q.insert(chunk_q.size(), 8'($urandom_range(127)));
    end else if (r < 60) begin
      encode_cp(legal_cp(len), len);
    end else if (r < 75) begin
      case ($urandom_range(2))
        0: begin
          // overlong: value fits a shorter form
          if (len == ucd_pkg::LEN2) cp = 21'($urandom_range(ucd_pkg::MIN_LEN2 - 1, 0));
          else if (len == ucd_pkg::LEN3) cp = 21'($urandom_range(ucd_pkg::MIN_LEN3 - 1, 0));
          else cp = 21'($urandom_range(ucd_pkg::MIN_LEN4 - 1, 0));
          encode_cp(cp, len);
        end
        1: encode_cp(21'($urandom_range(ucd_pkg::SURR_HI, ucd_pkg::SURR_LO)), ucd_pkg::LEN3);
        default: encode_cp(21'($urandom_range(21'h1FFFFF, ucd_pkg::CP_MAX + 1)), ucd_pkg::LEN4);
      endcase
    end else if (r < 87) begin
      // sequence cut short; a following byte that is not a continuation breaks it
      encode_cp(legal_cp(len), len);
      cut = $urandom_range(int'(len) - 1, 1);
      repeat (cut) void'(chunk_q.pop_back());
    end else begin
      chunk_q.insert(chunk_q.size(), 8'($urandom_range(255)));
    end
  endfunction

  // ---------------------------------------------------------------------------
  // code point receiver and checker
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    cp_res_t e;
    if (!rst && m_tvalid && m_tready) begin
      cp_seen++;
      if (m_tuser[0]) mal_seen++;
      if (m_tuser[1]) texts_seen++;
      if (cp_expect_q.size() == 0) begin
        $error("code point transaction with nothing expected: code_value %h", m_tdata[20:0]);
        err_count++;
      end else begin
        e = cp_expect_q.pop_front();
        if (m_tdata[20:0] !== e.value) begin
          $error("code_value: expected %h, got %h", e.value, m_tdata[20:0]);
          err_count++;
        end
        if (m_tuser[0] !== e.mal) begin
          $error("malformed: expected %b, got %b", e.mal, m_tuser[0]);
          err_count++;
        end
        if (m_tlast !== e.last) begin
          $error("last_of_run: expected %b, got %b", e.last, m_tlast);
          err_count++;
        end
        if (m_tuser[1] !== e.done) begin
          $error("text_done: expected %b, got %b", e.done, m_tuser[1]);
          err_count++;
        end
      end
    end
    if (rx_hold) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= rx_stall_pct);
  end

  // long receiver hold-off so the result queue fills and the input stalls
  always @(hold_go) begin
    rx_hold <= 1'b1;
    repeat (300) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    int         i;
    int         ph;
    int         n;
    logic [7:0] b;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = 8'h00;
    s_tlast  = 1'b0;
    seq_clear();
    for (i = 0; i < 3; i++) cont_q[i] = 6'd0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < DIR_N; i++) begin
      send_byte(DIR_ROWS[i].b, DIR_ROWS[i].eot, DIR_ROWS[i].typed, DIR_ROWS[i].cp,
                DIR_ROWS[i].mal);
    end
    // closes the open three-byte form with end of text
    send_byte(8'h88, 1'b1, 1'b0, 21'h0, 1'b0);
    s_tvalid <= 1'b0;
    drain();

    // phases: receiver hold-off without random idling, sender gaps, receiver stalls, both
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
          -> hold_go;
        end
        1: begin
          tx_idle_pct  = 48;
          rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 48;
        end
        default: begin
          tx_idle_pct  = 32;
          rx_stall_pct = 32;
        end
      endcase
      n = 0;
      while (n < 120) begin
        build_chunk();
        while (chunk_q.size() != 0) begin
          b = chunk_q.pop_front();
          send_byte(b, $urandom_range(29) == 0, 1'b0, 21'h0, 1'b0);
          n++;
        end
      end
      // sender waits here until every owed code point is back
      s_tvalid <= 1'b0;
      drain();
    end

    repeat (10) @(posedge clk);
    $display("sent %0d bytes; checked %0d code points, %0d of them malformed leads, %0d text ends",
             bytes_sent, cp_seen, mal_seen, texts_seen);
    if (err_count == 0) begin
      $display("PASS utf8_codepoint_decoder");
    end else begin
      $display("FAIL utf8_codepoint_decoder");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL utf8_codepoint_decoder");
    $finish;
  end

endmodule
